FILE: hw/rtl/rmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, limits and helpers for the matrix-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int IN_W  = 18;   // matrix entry width
  localparam int N_IN  = 9;    // matrix entries per beat
  localparam int N_Q   = 4;    // quaternion components
  localparam int OUT_W = 18;   // quaternion component width
  localparam int S_W   = 64;   // sum of squares width
  localparam int Y_W   = 32;   // reciprocal root, Q2.30
  localparam int X_W   = 30;   // normalized sum, Q0.30
  localparam int A_W   = 34;   // Newton intermediate width
  localparam int K_W   = 7;    // final shift width
  localparam int SH_W  = 8;    // signed normalization shift

  localparam logic [OUT_W:0] OUT_MAX_MAG = (OUT_W+1)'(131071);
  localparam logic [OUT_W:0] OUT_MIN_MAG = (OUT_W+1)'(131072);

  // Position of the highest set bit plus one; zero for a zero word.
  function automatic logic [6:0] bit_len(input logic [S_W-1:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < S_W; i++) begin
      if (v[i]) begin
        n = 7'(i + 1);
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/rotation_matrix_to_quaternion_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// Pipelined Shepperd conversion of a 3x3 rotation matrix to a unit quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one beat carries a whole matrix, nine signed
//   entries with FRAC_BITS fraction bits, row-major from the lowest bits.
//   Output channel (out_*): one beat per matrix, qx qy qz qw in tdata and
//   the degenerate flag in tuser (set when the sum of squares is zero, with
//   all four components forced to zero).
//   Stages from input beat to output beat: branch select, squares, sum,
//   leading-one search, normalize and seed, three stages per Newton step
//   (RSQRT_ITERATIONS steps, four by default), scale multiply, then
//   round/saturate into the output register.
//   Throughput: one beat per cycle; every stage is a register with a valid
//   bit, so a new matrix may enter each cycle while earlier ones are in flight.
//   Stall: when the output register holds a beat that is not taken, the whole
//   pipeline holds and in_tready drops; nothing is lost or repeated.
//   Reset: rst_n is synchronous, active low; it clears all valid bits and
//   out_tvalid. Payload registers are not reset.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS        = 16,
  parameter int RSQRT_ITERATIONS = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // r00 r01 r02 r10 r11 r12 r20 r21 r22, 18 bits each, from bit 0; 6 pad bits
  input  wire logic [167:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // qx qy qz qw, 18 bits each, from bit 0
  output logic [71:0]       out_tdata,
  // degenerate
  output logic [0:0]        out_tuser
);

  localparam int T_W = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 3;
  localparam int NS  = 3 * RSQRT_ITERATIONS;
  localparam int P_W = T_W + Y_W;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // --------------------------------------------------------------------------
  // Stage 1: trace, branch select, raw components
  // --------------------------------------------------------------------------
  logic signed [T_W-1:0] e [N_IN];
  logic signed [T_W-1:0] one_c, tr;
  logic signed [T_W-1:0] t_nxt [N_Q];

  always_comb begin
    for (int i = 0; i < N_IN; i++) begin
      e[i] = T_W'($signed(in_tdata[i*IN_W +: IN_W]));
    end
    one_c = T_W'(1) <<< FRAC_BITS;
    tr    = e[0] + e[4] + e[8];
    if (tr >= e[0] && tr >= e[4] && tr >= e[8]) begin
      t_nxt[0] = e[7] - e[5];
      t_nxt[1] = e[2] - e[6];
      t_nxt[2] = e[3] - e[1];
      t_nxt[3] = one_c + tr;
    end else if (e[0] >= e[4] && e[0] >= e[8]) begin
      t_nxt[0] = one_c - tr + (e[0] <<< 1);
      t_nxt[1] = e[1] + e[3];
      t_nxt[2] = e[2] + e[6];
      t_nxt[3] = e[7] - e[5];
    end else if (e[4] >= e[8]) begin
      t_nxt[0] = e[1] + e[3];
      t_nxt[1] = one_c - tr + (e[4] <<< 1);
      t_nxt[2] = e[5] + e[7];
      t_nxt[3] = e[2] - e[6];
    end else begin
      t_nxt[0] = e[2] + e[6];
      t_nxt[1] = e[5] + e[7];
      t_nxt[2] = one_c - tr + (e[8] <<< 1);
      t_nxt[3] = e[3] - e[1];
    end
  end

  logic                  v1_r, v2_r, v3_r, v4_r;
  logic signed [T_W-1:0] t1_r [N_Q];
  logic signed [T_W-1:0] t2_r [N_Q];
  logic signed [T_W-1:0] t3_r [N_Q];
  logic signed [T_W-1:0] t4_r [N_Q];
  logic [S_W-1:0]        sq_r [N_Q];
  logic [S_W-1:0]        s3_r, s4_r;
  logic                  deg4_r;
  logic signed [SH_W-1:0] sh4_r;
  logic [K_W-1:0]        k4_r;

  // Stage 2 squares, stage 3 sum
  logic [T_W-1:0]   mag2 [N_Q];
  logic [2*T_W-1:0] sqw  [N_Q];
  logic [S_W-1:0]   s_sum;

  always_comb begin
    s_sum = '0;
    for (int i = 0; i < N_Q; i++) begin
      mag2[i] = t1_r[i][T_W-1] ? T_W'(-t1_r[i]) : T_W'(t1_r[i]);
      sqw[i]  = (2*T_W)'(mag2[i]) * (2*T_W)'(mag2[i]);
      s_sum   = s_sum + sq_r[i];
    end
  end

  // Stage 4: leading-one search, even shift, final scale shift
  logic [6:0]             p4;
  logic signed [SH_W-1:0] sh_nxt;
  logic [SH_W-1:0]        h_nxt;

  always_comb begin
    p4 = bit_len(s3_r);
    if (p4[0]) begin
      sh_nxt = SH_W'(61) - SH_W'(p4);
    end else begin
      sh_nxt = SH_W'(62) - SH_W'(p4);
    end
    h_nxt = (SH_W'(62) - sh_nxt) >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_Q; i++) begin
        t1_r[i] <= t_nxt[i];
        t2_r[i] <= t1_r[i];
        sq_r[i] <= S_W'(sqw[i]);
        t3_r[i] <= t2_r[i];
        t4_r[i] <= t3_r[i];
      end
      s3_r   <= s_sum;
      s4_r   <= s3_r;
      deg4_r <= (s3_r == '0);
      sh4_r  <= sh_nxt;
      k4_r   <= K_W'(30 + int'(h_nxt) - FRAC_BITS);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5 (index 0): normalize and seed; then three stages per Newton step
  // --------------------------------------------------------------------------
  logic [S_W-1:0]  m5;
  logic [X_W-1:0]  x5;
  logic [A_W-1:0]  seed5;
  logic [SH_W-1:0] nsh5;

  always_comb begin
    nsh5 = SH_W'(-sh4_r);
    if (!sh4_r[SH_W-1]) begin
      m5 = s4_r << sh4_r;
    end else begin
      m5 = s4_r >> nsh5;
    end
    x5    = m5[61:32];
    seed5 = (A_W'(9) << 28) - ((A_W'(5) * A_W'(x5)) >> 2);
  end

  localparam logic [A_W-1:0] THREE = A_W'(3) << 30;

  logic                  nv_r  [0:NS];
  logic signed [T_W-1:0] nt_r  [0:NS][N_Q];
  logic [X_W-1:0]        nx_r  [0:NS];
  logic [Y_W-1:0]        ny_r  [0:NS];
  logic [A_W-1:0]        na_r  [0:NS];
  logic                  nd_r  [0:NS];
  logic [K_W-1:0]        nk_r  [0:NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= NS; j++) begin
        nv_r[j] <= 1'b0;
      end
    end else if (en) begin
      nv_r[0] <= v4_r;
      for (int j = 0; j < NS; j++) begin
        nv_r[j+1] <= nv_r[j];
      end
    end
  end

  logic [2*Y_W-1:0]     yy   [NS];
  logic [X_W+A_W-1:0]   xt   [NS];
  logic [A_W-1:0]       uu   [NS];
  logic [2*Y_W-1:0]     yv   [NS];

  always_comb begin
    for (int j = 0; j < NS; j++) begin
      yy[j] = (2*Y_W)'(ny_r[j]) * (2*Y_W)'(ny_r[j]);
      xt[j] = (X_W+A_W)'(nx_r[j]) * (X_W+A_W)'(na_r[j]);
      uu[j] = A_W'(xt[j] >> 30);
      yv[j] = (2*Y_W)'(ny_r[j]) * (2*Y_W)'(na_r[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nt_r[0] <= t4_r;
      nx_r[0] <= x5;
      ny_r[0] <= Y_W'(seed5);
      na_r[0] <= '0;
      nd_r[0] <= deg4_r;
      nk_r[0] <= k4_r;
      for (int j = 0; j < NS; j++) begin
        nt_r[j+1] <= nt_r[j];
        nx_r[j+1] <= nx_r[j];
        nd_r[j+1] <= nd_r[j];
        nk_r[j+1] <= nk_r[j];
        case (j % 3)
          0: begin
            // square of the estimate
            ny_r[j+1] <= ny_r[j];
            na_r[j+1] <= A_W'(yy[j] >> 30);
          end
          1: begin
            // 3 - x*y^2, floored at zero
            ny_r[j+1] <= ny_r[j];
            na_r[j+1] <= (uu[j] < THREE) ? (THREE - uu[j]) : '0;
          end
          default: begin
            // y * (3 - x*y^2) / 2
            ny_r[j+1] <= Y_W'(yv[j] >> 31);
            na_r[j+1] <= na_r[j];
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scale multiply, then round half away from zero and saturate (zero if degenerate)
  // --------------------------------------------------------------------------
  logic           f1v_r, f1d_r;
  logic [P_W-1:0] f1p_r [N_Q];
  logic           f1n_r [N_Q];
  logic [K_W-1:0] f1k_r;
  logic [T_W-1:0] fmag [N_Q];

  always_comb begin
    for (int i = 0; i < N_Q; i++) begin
      fmag[i] = nt_r[NS][i][T_W-1] ? T_W'(-nt_r[NS][i]) : T_W'(nt_r[NS][i]);
    end
  end

  logic [P_W-1:0]   rnd  [N_Q];
  logic [P_W-1:0]   rmag [N_Q];
  logic [OUT_W-1:0] q_nxt [N_Q];

  always_comb begin
    for (int i = 0; i < N_Q; i++) begin
      rnd[i]  = f1p_r[i] + (P_W'(1) << (f1k_r - K_W'(1)));
      rmag[i] = rnd[i] >> f1k_r;
      if (f1d_r) begin
        q_nxt[i] = '0;
      end else if (f1n_r[i]) begin
        q_nxt[i] = (rmag[i] > P_W'(OUT_MIN_MAG)) ? OUT_W'(OUT_MIN_MAG)
                                                 : OUT_W'(-rmag[i]);
      end else begin
        q_nxt[i] = (rmag[i] > P_W'(OUT_MAX_MAG)) ? OUT_W'(OUT_MAX_MAG)
                                                 : OUT_W'(rmag[i]);
      end
    end
  end

  logic              out_tvalid_r;
  logic [71:0]       out_tdata_r;
  logic              out_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1v_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      f1v_r        <= nv_r[NS];
      out_tvalid_r <= f1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_Q; i++) begin
        f1p_r[i] <= P_W'(fmag[i]) * P_W'(ny_r[NS]);
        f1n_r[i] <= nt_r[NS][i][T_W-1];
        out_tdata_r[i*OUT_W +: OUT_W] <= q_nxt[i];
      end
      f1d_r     <= nd_r[NS];
      f1k_r     <= nk_r[NS];
      out_deg_r <= f1d_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_deg_r;

`ifndef SYNTHESIS
  // A degenerate beat carries an all-zero quaternion.
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("degenerate beat with nonzero quaternion");

  // A held output beat blocks the input side.
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while output stalled");

  // No output beat right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

FILE: test/rmq_quat_checker.sv
// ----------------------------------------------------------------------------
// rmq_quat_checker
// Watches the matrix and quaternion channels, predicts each quaternion from
// the accepted matrix and compares every field of the output beat.
// ----------------------------------------------------------------------------
module rmq_quat_checker
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS        = 16,
  parameter int RSQRT_ITERATIONS = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [167:0] in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [71:0]  out_tdata,
  input  wire logic [0:0]   out_tuser,
  output int                fail_count,
  output int                pending,
  output int                quat_seen,
  output int                degen_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              degen;
    logic [OUT_W-1:0]  qw, qz, qy, qx;
  } quat_t;

  quat_t quat_q[$];

  function automatic logic [OUT_W-1:0] scale_comp(longint t, logic [63:0] y, int k);
    logic [63:0] mag, r;
    mag = (t < 0) ? 64'(-t) : 64'(t);
    r = (mag * y + (64'd1 << (k - 1))) >> k;
    if (t < 0) return (r > 64'd131072) ? OUT_W'(-131072) : OUT_W'(-longint'(r));
    return (r > 64'd131071) ? OUT_W'(131071) : OUT_W'(r);
  endfunction

  function automatic quat_t predict_quat(logic [167:0] d);
    longint e[9];
    longint t[4];
    longint one, tr;
    logic [63:0] s, m, x30, y, t2, u, v, three;
    int p, sh, k;
    quat_t q;
    for (int i = 0; i < 9; i++) e[i] = longint'(signed'(d[i*IN_W +: IN_W]));
    one = longint'(1) << FRAC_BITS;
    tr = e[0] + e[4] + e[8];
    if (tr >= e[0] && tr >= e[4] && tr >= e[8]) begin
      t = '{e[7]-e[5], e[2]-e[6], e[3]-e[1], one+tr};
    end else if (e[0] >= e[4] && e[0] >= e[8]) begin
      t = '{one-tr+2*e[0], e[1]+e[3], e[2]+e[6], e[7]-e[5]};
    end else if (e[4] >= e[8]) begin
      t = '{e[1]+e[3], one-tr+2*e[4], e[5]+e[7], e[2]-e[6]};
    end else begin
      t = '{e[2]+e[6], e[5]+e[7], one-tr+2*e[8], e[3]-e[1]};
    end
    s = '0;
    for (int i = 0; i < 4; i++) s += 64'(t[i] * t[i]);
    q = '0;
    if (s == 0) begin
      q.degen = 1'b1;
      return q;
    end
    p = 0;
    for (int i = 0; i < 64; i++) if (s[i]) p = i + 1;
    sh = 62 - p;
    if (sh % 2 != 0) sh = 61 - p;
    m = (sh >= 0) ? (s << sh) : (s >> (-sh));
    x30 = m >> 32;
    y = (64'd9 << 28) - ((64'd5 * x30) >> 2);
    three = 64'd3 << 30;
    for (int i = 0; i < RSQRT_ITERATIONS; i++) begin
      t2 = (y * y) >> 30;
      u = (x30 * t2) >> 30;
      v = (u < three) ? three - u : 64'd0;
      y = (y * v) >> 31;
    end
    k = 30 + (62 - sh) / 2 - FRAC_BITS;
    q.qx = scale_comp(t[0], y, k);
    q.qy = scale_comp(t[1], y, k);
    q.qz = scale_comp(t[2], y, k);
    q.qw = scale_comp(t[3], y, k);
    return q;
  endfunction

  assign pending = quat_q.size();

  initial begin
    fail_count = 0;
    quat_seen = 0;
    degen_seen = 0;
  end

  always @(posedge clk) begin
    quat_t want, got;
    if (rst_n && in_tvalid && in_tready) quat_q.push_back(predict_quat(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata};
      quat_seen++;
      if (got.degen) degen_seen++;
      if (quat_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected quaternion beat %h", got);
      end else begin
        want = quat_q.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected deg=%b x=%h y=%h z=%h w=%h, got deg=%b x=%h y=%h z=%h w=%h",
                     want.degen, want.qx, want.qy, want.qz, want.qw,
                     got.degen, got.qx, got.qy, got.qz, got.qw);
        end
      end
    end
  end
endmodule

FILE: test/tb_rotation_matrix_to_quaternion_top.sv
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_top
// Drives directed and random matrices into the converter with random gaps and
// output stalls; the checker predicts and compares each quaternion.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  localparam int ONE_Q = 65536;
  localparam int WATCHDOG_LIMIT = 20000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [167:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;
  logic [0:0]   out_tuser;
  int           fail_count, pending, quat_seen, degen_seen;
  int           matrices_sent;
  int           idle_cycles;
  bit           hold_off;     // long receiver stall in progress

  rotation_matrix_to_quaternion_top uut (.*);

  rmq_quat_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .fail_count, .pending, .quat_seen, .degen_seen
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Pick a gap length: mostly zero or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [IN_W-1:0] rand_entry();
    case ($urandom_range(5))
      0: return IN_W'(-131072);
      1: return IN_W'(131071);
      2: return IN_W'($urandom_range(2 * ONE_Q) - ONE_Q);
      default: return IN_W'($urandom);
    endcase
  endfunction

  // Build a matrix from nine signed entries, row-major from bit 0.
  function automatic logic [167:0] pack_mat(int a[9]);
    logic [167:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*IN_W +: IN_W] = IN_W'(a[i]);
    return d;
  endfunction

  // Near-rotation: signed permutation of the identity plus small noise, so that
  // every Shepperd branch and both signs show up often.
  function automatic logic [167:0] rot_mat();
    int a[9];
    int perm[3];
    int j;
    perm = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(i);
      {perm[i], perm[j]} = {perm[j], perm[i]};
    end
    for (int i = 0; i < 9; i++) a[i] = int'($urandom_range(16000)) - 8000;
    for (int r = 0; r < 3; r++)
      a[r*3 + perm[r]] += ($urandom_range(1) ? ONE_Q : -ONE_Q) - 8000 + 8000;
    return pack_mat(a);
  endfunction

  // Offer one matrix after a random gap and hold it until accepted.
  task automatic send_mat(logic [167:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    matrices_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end else if ($urandom_range(3) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_rotation_matrix_to_quaternion_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int id[9];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    hold_off = 1'b0;
    matrices_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, each branch, zero matrix, extremes, tie cases.
    id = '{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q};
    send_mat(pack_mat(id));
    send_mat(pack_mat('{ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q}));
    send_mat(pack_mat('{-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q}));
    send_mat(pack_mat('{-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q}));
    send_mat(pack_mat('{0, -ONE_Q, 0, ONE_Q, 0, 0, 0, 0, ONE_Q}));
    send_mat('0);
    // trace of minus one with a tie on the other diagonal entries
    send_mat(pack_mat('{-ONE_Q, 0, 0, 0, 0, 0, 0, 0, 0}));
    send_mat(pack_mat('{131071, 131071, 131071, 131071, 131071, 131071,
                        131071, 131071, 131071}));
    send_mat(pack_mat('{-131072, -131072, -131072, -131072, -131072, -131072,
                        -131072, -131072, -131072}));
    send_mat(pack_mat('{-131072, 131071, -131072, 131071, -131072, 131071,
                        -131072, 131071, -131072}));
    send_mat(pack_mat('{131071, -131072, 131071, -131072, 131071, -131072,
                        131071, -131072, 131071}));
    send_mat({168{1'b1}});
    send_mat(pack_mat('{1, 0, 0, 0, 1, 0, 0, 0, 1}));
    send_mat(pack_mat('{0, 1, -1, 0, 0, 0, 0, 0, 0}));
    send_mat(pack_mat('{131071, 0, 0, 0, -131072, 0, 0, 0, -131072}));
    drain();

    // Long receiver stall while the sender keeps offering; fills the pipeline.
    hold_off = 1'b1;
    for (int i = 0; i < 60; i++) send_mat(rot_mat());
    drain();

    // Random: mostly near-rotations, the rest random entries with extremes mixed in.
    for (int i = 0; i < 880; i++) begin
      if ($urandom_range(9) < 7) send_mat(rot_mat());
      else begin
        logic [167:0] d;
        d = '0;
        for (int j = 0; j < 9; j++) d[j*IN_W +: IN_W] = rand_entry();
        send_mat(d);
      end
      if (i == 400) drain();
    end
    drain();
    repeat (40) @(posedge clk);

    $display("sent %0d matrices, checked %0d quaternions (%0d degenerate)",
             matrices_sent, quat_seen, degen_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_rotation_matrix_to_quaternion_top: PASS");
    end else begin
      $display("tb_rotation_matrix_to_quaternion_top: FAIL");
    end
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/rmq_pkg.sv
hw/rtl/rotation_matrix_to_quaternion_top.sv
test/rmq_quat_checker.sv
test/tb_rotation_matrix_to_quaternion_top.sv
